/* sv/bblt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblt_pkg
// Shared types, codes and reset values of the block background label tracker.
// ----------------------------------------------------------------------------
package bblt_pkg;

    // Block kinds as kept in the label store
    typedef enum logic [2:0] {
        KIND_UNDEF  = 3'd0,
        KIND_BG     = 3'd1,
        KIND_STILL  = 3'd2,
        KIND_ILLUM  = 3'd3,
        KIND_MOVING = 3'd4
    } kind_t;

    // Background update requested from the caller
    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_COPY  = 2'd1,
        ACT_BLEND = 2'd2,
        ACT_SIDE  = 2'd3
    } action_t;

    // One label store entry
    typedef struct packed {
        kind_t      kind;
        logic [7:0] count;
    } label_t;

    localparam int LABEL_W = $bits(label_t);

    // Result of one label update
    typedef struct packed {
        label_t  label;
        action_t action;
        logic    first_def;
    } update_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_CORR_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_STILL_LIMIT    = 2'd1;
    localparam logic [1:0] CFG_BLOCKS_IN_USE  = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Field widths
    localparam int INDEX_W = 12;
    localparam int CORR_W  = 16;
    localparam int COUNT_W = 8;
    localparam int BLOCKS_W = 13;

    // Reset values
    localparam logic [CORR_W-1:0]   CORR_THRESHOLD_RST = 16'd22938;  // 0.7 in Q1.15
    localparam logic [COUNT_W-1:0]  STILL_LIMIT_RST    = 8'd20;
    localparam logic [BLOCKS_W-1:0] BLOCKS_IN_USE_RST  = 13'd4096;

    localparam int MAX_BLOCKS_DEFAULT = 4096;

endpackage

/* sv/block_background_label_tracker.sv */
`timescale 1ns / 1ps
// Pipeline: the label is read into the store's read register as a word is
//   accepted; the update is computed in stage 1 and loaded into the output register.
// Throughput: one word per cycle while the result channel does not stall; the
//   label store does one read and one write per cycle, and a write-to-read
//   forward covers back-to-back hits on a block. Reset: after rst_n releases,
//   a clearing pass writes every label entry to undefined; in_ready stays low
//   until it ends. Configuration writes are taken during the pass.
// ----------------------------------------------------------------------------
// block_background_label_tracker
// Per-block background label store with update action and init tracking.
// ----------------------------------------------------------------------------
module block_background_label_tracker #(
    parameter int MAX_BLOCKS = bblt_pkg::MAX_BLOCKS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,

    // Configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bblt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bblt_pkg::CFG_DATA_W-1:0]    cfg_data,

    // Input channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [bblt_pkg::INDEX_W-1:0]       block_index,
    input  logic                               is_moving,
    input  logic [bblt_pkg::CORR_W-1:0]        corr_value,

    // Result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [2:0]                         new_kind,
    output logic [bblt_pkg::COUNT_W-1:0]       new_count,
    output logic [1:0]                         update_action,
    output logic [bblt_pkg::BLOCKS_W-1:0]      undefined_left,
    output logic                               init_done
);
    import bblt_pkg::*;

    localparam int ADDR_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_BLOCKS - 1);

    // ------------------------------------------------------------------
    // Configuration registers: the port never stalls
    // ------------------------------------------------------------------
    logic [CORR_W-1:0]   corr_threshold_reg;
    logic [COUNT_W-1:0]  still_limit_reg;
    logic [BLOCKS_W-1:0] blocks_in_use_reg;
    logic                cfg_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corr_threshold_reg <= CORR_THRESHOLD_RST;
            still_limit_reg    <= STILL_LIMIT_RST;
            blocks_in_use_reg  <= BLOCKS_IN_USE_RST;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                CFG_CORR_THRESHOLD: corr_threshold_reg <= cfg_data[CORR_W-1:0];
                CFG_STILL_LIMIT:    still_limit_reg    <= cfg_data[COUNT_W-1:0];
                CFG_BLOCKS_IN_USE:  blocks_in_use_reg  <= cfg_data[BLOCKS_W-1:0];
                default:            ;  // unmapped index: drop the word
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Clearing pass: sweep the label store to undefined after reset
    // ------------------------------------------------------------------
    logic              clear_busy_reg;
    logic [ADDR_W-1:0] clear_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clear_busy_reg)
        begin
            clear_addr_reg <= clear_addr_reg + ADDR_W'(1);
            if (clear_addr_reg == LAST_ADDR)
            begin
                clear_busy_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    //   stage 0: accept word, issue label read
    //   stage 1: label data back, compute update, write back, load output
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic s1_adv;
    logic in_fire;

    // Stage 1 moves on whenever the output register is free or being drained
    assign s1_adv   = !out_valid_reg || out_ready;
    assign in_ready = !clear_busy_reg && (!s1_valid_reg || s1_adv);
    assign in_fire  = in_valid && in_ready;

    // Stage 1 payload
    logic [INDEX_W-1:0] s1_index_reg;
    logic               s1_moving_reg;
    logic [CORR_W-1:0]  s1_corr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_index_reg  <= block_index;
            s1_moving_reg <= is_moving;
            s1_corr_reg   <= corr_value;
        end
    end

    // ------------------------------------------------------------------
    // Label store
    // ------------------------------------------------------------------
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [LABEL_W-1:0] ram_wdata;
    logic [LABEL_W-1:0] ram_rdata;
    logic [ADDR_W-1:0] s1_addr;
    logic              s1_in_range;
    logic              s1_write;
    update_t           upd;

    assign s1_addr = ADDR_W'(s1_index_reg);

    // Out-of-range blocks leave the store alone and answer undefined / none
    assign s1_in_range = (32'(s1_index_reg) < MAX_BLOCKS) &&
                         ({1'b0, s1_index_reg} < blocks_in_use_reg);
    assign s1_write    = s1_valid_reg && s1_adv && s1_in_range;

    always_comb
    begin
        if (clear_busy_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clear_addr_reg;
            ram_wdata = '0;  // undefined kind, count zero
        end
        else
        begin
            ram_we    = s1_write;
            ram_waddr = s1_addr;
            ram_wdata = upd.label;
        end
    end

    bblt_ram #(
        .WIDTH  (LABEL_W),
        .DEPTH  (MAX_BLOCKS),
        .ADDR_W (ADDR_W)
    ) u_label_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_fire),
        .raddr (ADDR_W'(block_index)),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Forwarding: the store returns old data when a word reads the entry
    // being written in the same cycle. Capture that write at the read edge
    // and hold it while the word waits in stage 1.
    // ------------------------------------------------------------------
    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    label_t            fwd_label_reg;
    label_t            prev_label;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            fwd_valid_reg <= s1_write;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            fwd_addr_reg  <= s1_addr;
            fwd_label_reg <= upd.label;
        end
    end

    assign prev_label = (fwd_valid_reg && fwd_addr_reg == s1_addr) ? fwd_label_reg
                                                                    : label_t'(ram_rdata);

    // ------------------------------------------------------------------
    // Label update
    // ------------------------------------------------------------------
    bblt_next_label u_next_label (
        .prev           (prev_label),
        .moving         (s1_moving_reg),
        .corr           (s1_corr_reg),
        .corr_threshold (corr_threshold_reg),
        .still_limit    (still_limit_reg),
        .upd            (upd)
    );

    // ------------------------------------------------------------------
    // Undefined block count: reloaded by a blocks_in_use write, counted
    // down on each first definition, held at zero
    // ------------------------------------------------------------------
    logic [BLOCKS_W-1:0] undef_count_reg;
    logic [BLOCKS_W-1:0] undef_count_next;

    always_comb
    begin
        undef_count_next = undef_count_reg;
        if (s1_write && upd.first_def && undef_count_reg != '0)
        begin
            undef_count_next = undef_count_reg - BLOCKS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            undef_count_reg <= BLOCKS_IN_USE_RST;
        end
        else if (cfg_fire && cfg_index == CFG_BLOCKS_IN_USE)
        begin
            undef_count_reg <= cfg_data[BLOCKS_W-1:0];
        end
        else
        begin
            undef_count_reg <= undef_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register: holds the result while the consumer stalls
    // ------------------------------------------------------------------
    logic [2:0]          out_kind_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [1:0]          out_action_reg;
    logic [BLOCKS_W-1:0] out_undef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            if (s1_in_range)
            begin
                out_kind_reg   <= upd.label.kind;
                out_count_reg  <= upd.label.count;
                out_action_reg <= upd.action;
            end
            else
            begin
                out_kind_reg   <= KIND_UNDEF;
                out_count_reg  <= '0;
                out_action_reg <= ACT_NONE;
            end
            out_undef_reg <= undef_count_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign new_kind       = out_kind_reg;
    assign new_count      = out_count_reg;
    assign update_action  = out_action_reg;
    assign undefined_left = out_undef_reg;
    assign init_done      = (out_undef_reg == '0);

endmodule

/* sv/bblt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblt_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// A read of the address written in the same cycle returns the old data.
// ----------------------------------------------------------------------------
module bblt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/bblt_next_label.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblt_next_label
// Label transition: new kind and count from the previous label, the motion
// verdict and the correlation, plus the background update to request.
// ----------------------------------------------------------------------------
module bblt_next_label (
    input  bblt_pkg::label_t               prev,
    input  logic                           moving,
    input  logic [bblt_pkg::CORR_W-1:0]    corr,
    input  logic [bblt_pkg::CORR_W-1:0]    corr_threshold,
    input  logic [bblt_pkg::COUNT_W-1:0]   still_limit,
    output bblt_pkg::update_t              upd
);
    import bblt_pkg::*;

    logic [COUNT_W:0]   still_inc;
    logic [COUNT_W-1:0] still_sat;

    // Still count + 1, saturated at the limit
    assign still_inc = {1'b0, prev.count} + (COUNT_W+1)'(1);
    assign still_sat = (still_inc > {1'b0, still_limit}) ? still_limit
                                                         : still_inc[COUNT_W-1:0];

    always_comb
    begin
        upd.label.kind  = KIND_UNDEF;
        upd.label.count = '0;
        upd.action      = ACT_NONE;
        upd.first_def   = 1'b0;

        if (prev.kind == KIND_UNDEF && moving)
        begin
            upd.label.kind = KIND_UNDEF;
        end
        else if (!moving)
        begin
            if (corr > corr_threshold)
            begin
                upd.label.kind = KIND_BG;
            end
            else
            begin
                upd.label.kind = KIND_STILL;
                if (prev.kind == KIND_STILL)
                begin
                    upd.label.count = still_sat;
                end
            end
        end
        else
        begin
            if (corr < corr_threshold)
            begin
                upd.label.kind  = KIND_MOVING;
                upd.label.count = (prev.kind == KIND_MOVING) ? COUNT_W'(1) : '0;
            end
            else
            begin
                upd.label.kind = KIND_ILLUM;
            end
        end

        if (upd.label.kind != KIND_UNDEF)
        begin
            if (prev.kind == KIND_UNDEF &&
                (upd.label.kind == KIND_BG || upd.label.kind == KIND_STILL))
            begin
                upd.action    = ACT_COPY;
                upd.first_def = 1'b1;
            end
            else if (upd.label.kind == KIND_BG || upd.label.kind == KIND_ILLUM)
            begin
                upd.action = ACT_BLEND;
            end
            else if (upd.label.kind == KIND_STILL)
            begin
                if (upd.label.count >= still_limit)
                begin
                    upd.action = ACT_COPY;
                end
            end
            else if (upd.label.kind == KIND_MOVING && upd.label.count == COUNT_W'(1))
            begin
                upd.action = ACT_SIDE;
            end
        end
    end

endmodule

/* tb/bblt_label_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblt_label_checker
// Watches the register, input and result channels of the label tracker. It
// keeps its own label store and counters, predicts one result word per input
// word and compares each result word with the oldest prediction.
// ----------------------------------------------------------------------------
module bblt_label_checker #(
    parameter int MAX_BLOCKS = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [bblt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bblt_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic [bblt_pkg::INDEX_W-1:0]       block_index,
    input  logic                               is_moving,
    input  logic [bblt_pkg::CORR_W-1:0]        corr_value,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [2:0]                         new_kind,
    input  logic [bblt_pkg::COUNT_W-1:0]       new_count,
    input  logic [1:0]                         update_action,
    input  logic [bblt_pkg::BLOCKS_W-1:0]      undefined_left,
    input  logic                               init_done,
    output int                                 fail_count,
    output int                                 pending
);

    import bblt_pkg::*;

    typedef struct packed {
        kind_t               kind;
        logic [COUNT_W-1:0]  count;
        action_t             action;
        logic [BLOCKS_W-1:0] undef_left;
        logic                done;
    } label_result_t;

    kind_t               lbl_kind  [MAX_BLOCKS];
    logic [COUNT_W-1:0]  lbl_count [MAX_BLOCKS];
    logic [CORR_W-1:0]   thr;
    logic [COUNT_W-1:0]  lim;
    logic [BLOCKS_W-1:0] blocks_used;
    logic [BLOCKS_W-1:0] undef_cnt;

    label_result_t expected_labels[$];
    label_result_t head;
    int            mismatches = 0;

    // Update one block label and return the result word it should produce
    function automatic label_result_t track_block(logic [INDEX_W-1:0] idx, logic mv,
                                                  logic [CORR_W-1:0] corr);
        kind_t              pk;
        kind_t              nk;
        logic [COUNT_W-1:0] pc;
        logic [COUNT_W-1:0] nc;
        logic [COUNT_W:0]   inc;
        action_t            act;
        label_result_t      r;
        nk  = KIND_UNDEF;
        nc  = '0;
        act = ACT_NONE;
        if (int'(idx) < MAX_BLOCKS && idx < blocks_used)
        begin
            pk = lbl_kind[idx];
            pc = lbl_count[idx];
            if (pk == KIND_UNDEF && mv)
            begin
                nk = KIND_UNDEF;
            end
            else if (!mv)
            begin
                if (corr > thr)
                begin
                    nk = KIND_BG;
                end
                else
                begin
                    nk = KIND_STILL;
                    if (pk == KIND_STILL)
                    begin
                        inc = {1'b0, pc} + 1'b1;
                        nc  = (inc > {1'b0, lim}) ? lim : inc[COUNT_W-1:0];
                    end
                end
            end
            else
            begin
                if (corr < thr)
                begin
                    nk = KIND_MOVING;
                    nc = (pk == KIND_MOVING) ? 8'd1 : 8'd0;
                end
                else
                begin
                    nk = KIND_ILLUM;
                end
            end

            if (nk != KIND_UNDEF)
            begin
                if (pk == KIND_UNDEF && (nk == KIND_BG || nk == KIND_STILL))
                begin
                    act = ACT_COPY;
                    if (undef_cnt != 0)
                        undef_cnt = undef_cnt - 1'b1;
                end
                else if (nk == KIND_BG || nk == KIND_ILLUM)
                    act = ACT_BLEND;
                else if (nk == KIND_STILL)
                begin
                    if (nc >= lim)
                        act = ACT_COPY;
                end
                else if (nk == KIND_MOVING && nc == 8'd1)
                    act = ACT_SIDE;
            end
            lbl_kind[idx]  = nk;
            lbl_count[idx] = nc;
        end
        r.kind       = nk;
        r.count      = nc;
        r.action     = act;
        r.undef_left = undef_cnt;
        r.done       = (undef_cnt == 0);
        return r;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        if (mismatches < 200)
            $display("[%0t] MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_BLOCKS; i++)
            begin
                lbl_kind[i]  = KIND_UNDEF;
                lbl_count[i] = '0;
            end
            thr         = CORR_THRESHOLD_RST;
            lim         = STILL_LIMIT_RST;
            blocks_used = BLOCKS_IN_USE_RST;
            undef_cnt   = BLOCKS_IN_USE_RST;
            expected_labels.delete();
            pending    <= 0;
            fail_count <= mismatches;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CORR_THRESHOLD: thr = cfg_data[CORR_W-1:0];
                    CFG_STILL_LIMIT:    lim = cfg_data[COUNT_W-1:0];
                    CFG_BLOCKS_IN_USE:
                    begin
                        blocks_used = cfg_data[BLOCKS_W-1:0];
                        undef_cnt   = cfg_data[BLOCKS_W-1:0];
                    end
                    default: ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                if (expected_labels.size() == 0)
                    flag_mismatch("unexpected result word", 1, 0);
                else
                begin
                    head = expected_labels.pop_front();
                    if (new_kind !== head.kind)
                        flag_mismatch("new_kind", new_kind, head.kind);
                    if (new_count !== head.count)
                        flag_mismatch("new_count", new_count, head.count);
                    if (update_action !== head.action)
                        flag_mismatch("update_action", update_action, head.action);
                    if (undefined_left !== head.undef_left)
                        flag_mismatch("undefined_left", undefined_left, head.undef_left);
                    if (init_done !== head.done)
                        flag_mismatch("init_done", init_done, head.done);
                end
            end

            if (in_valid && in_ready)
                expected_labels.push_back(track_block(block_index, is_moving, corr_value));

            pending    <= expected_labels.size();
            fail_count <= mismatches;
        end
    end

endmodule

/* tb/block_background_label_tracker_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_background_label_tracker_tb
// Drives the label tracker with a directed sweep of label transitions, then
// four random phases under different register settings and idle profiles,
// including a long result stall. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module block_background_label_tracker_tb;

    import bblt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 8;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [INDEX_W-1:0]     block_index;
    logic                   is_moving;
    logic [CORR_W-1:0]      corr_value;
    logic                   out_valid;
    logic                   out_ready;
    logic [2:0]             new_kind;
    logic [COUNT_W-1:0]     new_count;
    logic [1:0]             update_action;
    logic [BLOCKS_W-1:0]    undefined_left;
    logic                   init_done;

    int fail_count;
    int pending;

    // Idle profile shared by the word source and the result sink
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit rx_hold_req  = 1'b0;

    // Mirror of the settings, used only to aim the stimulus
    int cur_thr = 22938;
    int cur_bu  = 4096;

    int words_sent  = 0;
    int cycle_count = 0;

    block_background_label_tracker dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .block_index    (block_index),
        .is_moving      (is_moving),
        .corr_value     (corr_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .new_kind       (new_kind),
        .new_count      (new_count),
        .update_action  (update_action),
        .undefined_left (undefined_left),
        .init_done      (init_done)
    );

    bblt_label_checker #(
        .MAX_BLOCKS (MAX_BLOCKS_DEFAULT)
    ) label_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .block_index    (block_index),
        .is_moving      (is_moving),
        .corr_value     (corr_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .new_kind       (new_kind),
        .new_count      (new_count),
        .update_action  (update_action),
        .undefined_left (undefined_left),
        .init_done      (init_done),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Offer one input word; hold it until the block takes it. Valid stays high
    // on return so a following word can go out on the next edge.
    task automatic send_word(int idx, bit mv, int corr);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        block_index <= idx[INDEX_W-1:0];
        is_moving   <= mv;
        corr_value  <= corr[CORR_W-1:0];
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
    endtask

    // Drop valid and wait until every predicted result word has come back.
    // The extra edge lets the checker count a word taken on the last edge.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_reg(logic [CFG_INDEX_W-1:0] idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == CFG_CORR_THRESHOLD)
            cur_thr = value;
        if (idx == CFG_BLOCKS_IN_USE)
            cur_bu = value;
    endtask

    // Start a phase: go idle, load all registers, switch the idle profile
    task automatic configure(int thr, int lim, int bu, int tx_pct, int rx_pct);
        drain();
        set_reg(CFG_CORR_THRESHOLD, thr);
        set_reg(CFG_STILL_LIMIT, lim);
        set_reg(CFG_BLOCKS_IN_USE, bu);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    // Mostly revisit a small set of blocks so labels build up history;
    // sometimes hit anywhere, sometimes past the blocks in use.
    function automatic int pick_index(int span);
        int r;
        r = $urandom_range(99);
        if (r < 85)
            return $urandom_range(span - 1);
        else if (r < 93 || cur_bu >= 4096)
            return $urandom_range(4095);
        else
            return $urandom_range(4095, cur_bu);
    endfunction

    // Favor the extremes and values around the threshold
    function automatic int pick_corr();
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 10)
            v = 0;
        else if (r < 20)
            v = 32768;
        else if (r < 55)
            v = cur_thr + int'($urandom_range(4)) - 2;
        else
            v = $urandom_range(32768);
        if (v < 0)
            v = 0;
        if (v > 32768)
            v = 32768;
        return v;
    endfunction

    task automatic send_mixed(int span, int moving_pct);
        send_word(pick_index(span), $urandom_range(99) < moving_pct, pick_corr());
    endtask

    // Result sink: random stalls per profile, or a long hold-off on request
    initial
    begin : result_sink
        int hold_left;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold_left   = HOLD_CYCLES;
                out_ready  <= 1'b0;
                while (hold_left > 0)
                begin
                    @(posedge clk);
                    hold_left--;
                end
            end
            else
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog: end the run if it takes far longer than any correct run could
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Cycle limit of %0d reached, %0d result words outstanding",
                 CYCLE_LIMIT, pending);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_CORR_THRESHOLD;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        block_index <= '0;
        is_moving   <= 1'b0;
        corr_value  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed sweep at reset settings: threshold 0.7, limit 20, all blocks
        send_word(0, 1, 0);           // undefined and moving: stays undefined
        send_word(0, 0, 32768);       // first definition as background: copy
        send_word(0, 0, 32768);       // background again: blend
        send_word(0, 1, 0);           // moving, first frame
        send_word(0, 1, 0);           // moving twice: side match check
        send_word(0, 1, 22938);       // at threshold: illumination change
        send_word(0, 1, 22937);       // just below threshold: moving again
        send_word(4095, 0, 22938);    // at threshold static: still, first copy
        send_word(4095, 0, 0);        // still count advances
        send_word(4095, 0, 22939);    // just above threshold: background
        send_word(1, 0, 22939);
        send_word(1, 1, 32768);
        send_word(2, 1, 32767);
        send_word(2, 0, 0);
        send_word(2730, 0, 21845);

        // Small still limit and few blocks: saturation and out of range
        drain();
        set_reg(CFG_STILL_LIMIT, 2);
        set_reg(CFG_BLOCKS_IN_USE, 8);
        send_word(3, 0, 0);
        send_word(3, 0, 0);
        send_word(3, 0, 0);           // reaches the limit: copy
        send_word(3, 0, 0);           // held at the limit
        send_word(8, 0, 0);           // first block past those in use
        send_word(4095, 0, 0);        // far out of range

        // Raise the limit, build the count, then lower it below the count
        drain();
        set_reg(CFG_STILL_LIMIT, 5);
        send_word(3, 0, 0);
        send_word(3, 0, 0);
        drain();
        set_reg(CFG_STILL_LIMIT, 1);
        send_word(3, 0, 0);

        // Phase 1: no idling; a long result stall fills the block mid-phase
        configure(22938, 20, 16, 0, 0);
        for (int i = 0; i < 450; i++)
        begin
            if (i == 100)
                rx_hold_req = 1'b1;
            send_mixed(16, 40);
        end

        // Phase 2: zero threshold and limit, one block; source idles often
        configure(0, 0, 1, 45, 0);
        for (int i = 0; i < 250; i++)
            send_mixed(1, 30);

        // Phase 3: full-scale threshold, top limit; sink stalls often.
        // Open with a long static run so the still count saturates.
        configure(32768, 250, 2, 0, 45);
        for (int i = 0; i < 400; i++)
        begin
            if (i < 260)
                send_word(0, 0, pick_corr());
            else
                send_mixed(2, 10);
        end

        // Phase 4: random threshold, all blocks, light idling on both sides;
        // pause the source once until everything has come back
        configure($urandom_range(32768), 5, 4096, 10, 10);
        for (int i = 0; i < 450; i++)
        begin
            if (i == 225)
                drain();
            send_mixed(64, 50);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d input words: directed label transitions, then four phases",
                 words_sent);
        $display("with thresholds 0..1.0, still limits 0..250, 1..4096 blocks, long stalls");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
